>>> rtl/hbe_pkg.sv
// Shared types, constants and state codes of the Huffman byte encoder.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package hbe_pkg;

   localparam int SYM_NUM    = 256;
   localparam int SYM_W      = $clog2(SYM_NUM);
   localparam int CNT_W      = 32;
   localparam int MAX_LEN    = 32;
   localparam int LEN_W      = 6;
   localparam int LEN_MAX    = 2**LEN_W - 1;
   localparam int CODE_W     = MAX_LEN;
   localparam int NODE_NUM   = 2 * SYM_NUM;
   localparam int NODE_AW    = $clog2(NODE_NUM);
   localparam int SUM_W      = CNT_W + SYM_W;
   localparam int DEP_W      = SYM_W;
   localparam int TOT_W      = 40;
   localparam int ACC_W      = CODE_W + 8;
   localparam int REM_W      = $clog2(ACC_W + 1);
   localparam int INQ_DEPTH  = 2;
   localparam int OUTQ_DEPTH = 4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_LONG = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_TOTAL = 1'b1;

   typedef enum logic [1:0] {
      OP_COUNT,
      OP_BUILD,
      OP_ENCODE,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [SYM_W-1:0] symbol;
   } item_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       out_byte;
      logic [TOT_W-1:0] bit_total;
      logic [1:0]       status;
      logic             last;
   } res_type;

   typedef struct packed {
      logic [SUM_W-1:0]   count;
      logic [NODE_AW-1:0] id;
   } list_ent_type;

   typedef struct packed {
      logic [NODE_AW-1:0] left;
      logic [NODE_AW-1:0] right;
   } node_ent_type;

   typedef struct packed {
      logic [DEP_W-1:0]  depth;
      logic [CODE_W-1:0] code;
   } dc_ent_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } code_ent_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CNT_WR,
      S_ENC_CHK,
      S_ENC_EMIT,
      S_FL_BYTE,
      S_FL_TOT,
      S_SC_RD,
      S_SC_CHK,
      S_IN_RD,
      S_IN_CMP,
      S_IN_PUT,
      S_MG_START,
      S_MG_R,
      S_MG_L,
      S_TR_CHK,
      S_TR_W1,
      S_TR_W2,
      S_AS_RD,
      S_AS_WR,
      S_BD_RES
   } st_type;

endpackage

`default_nettype wire

>>> rtl/hbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/hbe_front.sv
// Input side: decodes the function code and holds a short queue of items.
// Depends on hbe_pkg.
`default_nettype none

module hbe_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [1:0]        req_func,
   input  wire logic [7:0]        req_symbol,
   output logic                   item_valid,
   output hbe_pkg::item_type      item,
   input  wire logic              item_pop
);

   localparam int PW = $clog2(hbe_pkg::INQ_DEPTH);
   localparam int CW = $clog2(hbe_pkg::INQ_DEPTH + 1);

   hbe_pkg::item_type q_ff [hbe_pkg::INQ_DEPTH];
   hbe_pkg::item_type dec;
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              do_push, do_pop;

   // classify the function code
   always_comb begin
      dec.symbol = req_symbol;
      unique case (req_func)
         2'd0: dec.op = hbe_pkg::OP_COUNT;
         2'd1: dec.op = hbe_pkg::OP_BUILD;
         2'd2: dec.op = hbe_pkg::OP_ENCODE;
         2'd3: dec.op = hbe_pkg::OP_FLUSH;
      endcase
   end

   assign full       = (cnt_ff == CW'(hbe_pkg::INQ_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = q_ff[rp_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == PW'(hbe_pkg::INQ_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_pop) begin
         rp_in = (rp_ff == PW'(hbe_pkg::INQ_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

>>> rtl/hbe_outq.sv
// Result queue between the executing back end and the result ports.
// Depends on hbe_pkg.
`default_nettype none

module hbe_outq (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         res_push,
   input  hbe_pkg::res_type  res,
   output logic              res_full,
   output logic              empty,
   input  wire logic         pop,
   output hbe_pkg::res_type  head
);

   localparam int PW = $clog2(hbe_pkg::OUTQ_DEPTH);
   localparam int CW = $clog2(hbe_pkg::OUTQ_DEPTH + 1);

   hbe_pkg::res_type q_ff [hbe_pkg::OUTQ_DEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [CW-1:0]    cnt_ff;
   logic             do_push, do_pop;

   assign res_full = (cnt_ff == CW'(hbe_pkg::OUTQ_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head     = q_ff[rp_ff];
   assign do_push  = res_push && !res_full;
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (do_pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= res;
      end
   end

endmodule

`default_nettype wire

>>> rtl/hbe_back.sv
// Back end: histogram, tree build sequencer, code table and bit packer.
// Depends on hbe_pkg and hbe_ram.
`default_nettype none

module hbe_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         item_valid,
   input  hbe_pkg::item_type item,
   output logic              item_pop,
   input  wire logic         res_full,
   output logic              res_push,
   output hbe_pkg::res_type  res
);

   localparam int SW = hbe_pkg::SYM_W;
   localparam int NW = hbe_pkg::NODE_AW;
   localparam logic [hbe_pkg::CNT_W-1:0] CMAX = '1;

   hbe_pkg::st_type state_ff, state_in;

   logic [SW-1:0]             sym_ff, sym_in;
   logic [NW-1:0]             idx_ff, idx_in, j_ff, j_in, n_ff, n_in;
   logic [NW-1:0]             nleaf_ff, nleaf_in, nodes_ff, nodes_in;
   logic [NW-1:0]             keyid_ff, keyid_in, rid_ff, rid_in;
   logic [hbe_pkg::SUM_W-1:0] key_ff, key_in, rcnt_ff, rcnt_in;
   logic                      merge_ff, merge_in, long_ff, long_in, sat_ff, sat_in;
   logic                      hv_q_ff, hv_q_in;
   logic [hbe_pkg::SYM_NUM-1:0] hvalid_ff, hvalid_in;
   logic [7:0]                pbits_ff, pbits_in;
   logic [2:0]                pcnt_ff, pcnt_in;
   logic [hbe_pkg::TOT_W-1:0] tot_ff, tot_in, tot_next;
   logic [hbe_pkg::TOT_W:0]   tot_sum;
   logic [hbe_pkg::ACC_W-1:0] acc_ff, acc_in, enc_acc;
   logic [hbe_pkg::REM_W-1:0] rem_ff, rem_in, enc_rem, rem_m8;

   logic                      hist_wr_en, hist_rd_en;
   logic [SW-1:0]             hist_wr_addr, hist_rd_addr;
   logic [hbe_pkg::CNT_W-1:0] hist_wr_data, hist_rd_data, hist_cur;

   logic                      code_wr_en, code_rd_en;
   logic [SW-1:0]             code_wr_addr, code_rd_addr;
   hbe_pkg::code_ent_type     code_wr_data, code_rd_data;

   logic                      list_wr_en, list_rd_en;
   logic [NW-1:0]             list_wr_addr, list_rd_addr;
   hbe_pkg::list_ent_type     list_wr_data, list_rd_data;

   logic                      node_wr_en, node_rd_en;
   logic [NW-1:0]             node_wr_addr, node_rd_addr;
   hbe_pkg::node_ent_type     node_wr_data, node_rd_data;

   logic                      dc_wr_en, dc_rd_en;
   logic [NW-1:0]             dc_wr_addr, dc_rd_addr;
   hbe_pkg::dc_ent_type       dc_wr_data, dc_rd_data;

   logic                      code_long, scan_end, list_less;

   hbe_ram #(.WIDTH(hbe_pkg::CNT_W), .DEPTH(hbe_pkg::SYM_NUM)) u_hist (
      .clock(clock), .wr_en(hist_wr_en), .wr_addr(hist_wr_addr), .wr_data(hist_wr_data),
      .rd_en(hist_rd_en), .rd_addr(hist_rd_addr), .rd_data(hist_rd_data));

   hbe_ram #(.WIDTH($bits(hbe_pkg::code_ent_type)), .DEPTH(hbe_pkg::SYM_NUM)) u_code (
      .clock(clock), .wr_en(code_wr_en), .wr_addr(code_wr_addr), .wr_data(code_wr_data),
      .rd_en(code_rd_en), .rd_addr(code_rd_addr), .rd_data(code_rd_data));

   hbe_ram #(.WIDTH($bits(hbe_pkg::list_ent_type)), .DEPTH(hbe_pkg::NODE_NUM)) u_list (
      .clock(clock), .wr_en(list_wr_en), .wr_addr(list_wr_addr), .wr_data(list_wr_data),
      .rd_en(list_rd_en), .rd_addr(list_rd_addr), .rd_data(list_rd_data));

   hbe_ram #(.WIDTH($bits(hbe_pkg::node_ent_type)), .DEPTH(hbe_pkg::NODE_NUM)) u_node (
      .clock(clock), .wr_en(node_wr_en), .wr_addr(node_wr_addr), .wr_data(node_wr_data),
      .rd_en(node_rd_en), .rd_addr(node_rd_addr), .rd_data(node_rd_data));

   hbe_ram #(.WIDTH($bits(hbe_pkg::dc_ent_type)), .DEPTH(hbe_pkg::NODE_NUM)) u_dc (
      .clock(clock), .wr_en(dc_wr_en), .wr_addr(dc_wr_addr), .wr_data(dc_wr_data),
      .rd_en(dc_rd_en), .rd_addr(dc_rd_addr), .rd_data(dc_rd_data));

   // an entry never written since reset reads as zero
   assign hist_cur  = hv_q_ff ? hist_rd_data : '0;
   assign code_long = (32'(code_rd_data.len) > hbe_pkg::MAX_LEN);
   assign scan_end  = (idx_ff == NW'(hbe_pkg::SYM_NUM - 1));
   assign list_less = (list_rd_data.count < key_ff);

   assign enc_acc  = hbe_pkg::ACC_W'(pbits_ff)
                   | (hbe_pkg::ACC_W'(code_rd_data.bits) << pcnt_ff);
   assign enc_rem  = hbe_pkg::REM_W'(pcnt_ff) + hbe_pkg::REM_W'(code_rd_data.len);
   assign tot_sum  = {1'b0, tot_ff} + (hbe_pkg::TOT_W + 1)'(code_rd_data.len);
   assign tot_next = tot_sum[hbe_pkg::TOT_W] ? '1 : tot_sum[hbe_pkg::TOT_W-1:0];
   assign rem_m8   = rem_ff - hbe_pkg::REM_W'(8);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hbe_pkg::S_IDLE: begin
            if (item_valid) begin
               unique case (item.op)
                  hbe_pkg::OP_COUNT:  state_in = hbe_pkg::S_CNT_WR;
                  hbe_pkg::OP_BUILD:  state_in = hbe_pkg::S_SC_RD;
                  hbe_pkg::OP_ENCODE: state_in = hbe_pkg::S_ENC_CHK;
                  hbe_pkg::OP_FLUSH:  state_in = hbe_pkg::S_FL_BYTE;
               endcase
            end
         end
         hbe_pkg::S_CNT_WR: state_in = hbe_pkg::S_IDLE;
         hbe_pkg::S_ENC_CHK: begin
            if (code_long) begin
               if (!res_full) state_in = hbe_pkg::S_IDLE;
            end else if (enc_rem < hbe_pkg::REM_W'(8)) begin
               state_in = hbe_pkg::S_IDLE;
            end else begin
               state_in = hbe_pkg::S_ENC_EMIT;
            end
         end
         hbe_pkg::S_ENC_EMIT: begin
            if (!res_full && rem_m8 < hbe_pkg::REM_W'(8)) state_in = hbe_pkg::S_IDLE;
         end
         hbe_pkg::S_FL_BYTE: begin
            if (pcnt_ff == '0 || !res_full) state_in = hbe_pkg::S_FL_TOT;
         end
         hbe_pkg::S_FL_TOT: begin
            if (!res_full) state_in = hbe_pkg::S_IDLE;
         end
         hbe_pkg::S_SC_RD: state_in = hbe_pkg::S_SC_CHK;
         hbe_pkg::S_SC_CHK: begin
            if (hist_cur != '0) begin
               state_in = hbe_pkg::S_IN_RD;
            end else if (scan_end) begin
               state_in = hbe_pkg::S_MG_START;
            end else begin
               state_in = hbe_pkg::S_SC_RD;
            end
         end
         hbe_pkg::S_IN_RD: begin
            state_in = (j_ff == '0) ? hbe_pkg::S_IN_PUT : hbe_pkg::S_IN_CMP;
         end
         hbe_pkg::S_IN_CMP: begin
            state_in = list_less ? hbe_pkg::S_IN_RD : hbe_pkg::S_IN_PUT;
         end
         hbe_pkg::S_IN_PUT: begin
            if (merge_ff || scan_end) begin
               state_in = hbe_pkg::S_MG_START;
            end else begin
               state_in = hbe_pkg::S_SC_RD;
            end
         end
         hbe_pkg::S_MG_START: begin
            if (n_ff > NW'(1)) begin
               state_in = hbe_pkg::S_MG_R;
            end else if (nleaf_ff == '0) begin
               state_in = hbe_pkg::S_BD_RES;
            end else begin
               state_in = hbe_pkg::S_TR_CHK;
            end
         end
         hbe_pkg::S_MG_R: state_in = hbe_pkg::S_MG_L;
         hbe_pkg::S_MG_L: state_in = hbe_pkg::S_IN_RD;
         hbe_pkg::S_TR_CHK: begin
            state_in = (idx_ff >= nleaf_ff) ? hbe_pkg::S_TR_W1 : hbe_pkg::S_AS_RD;
         end
         hbe_pkg::S_TR_W1: state_in = hbe_pkg::S_TR_W2;
         hbe_pkg::S_TR_W2: state_in = hbe_pkg::S_TR_CHK;
         hbe_pkg::S_AS_RD: state_in = hbe_pkg::S_AS_WR;
         hbe_pkg::S_AS_WR: begin
            state_in = ((idx_ff + 1'b1) == nleaf_ff) ? hbe_pkg::S_BD_RES : hbe_pkg::S_AS_RD;
         end
         hbe_pkg::S_BD_RES: begin
            if (!res_full) state_in = hbe_pkg::S_IDLE;
         end
         default: state_in = hbe_pkg::S_IDLE;
      endcase
   end

   // datapath, memory ports and results
   always_comb begin
      item_pop  = 1'b0;
      res_push  = 1'b0;
      res       = '0;
      sym_in    = sym_ff;
      idx_in    = idx_ff;
      j_in      = j_ff;
      n_in      = n_ff;
      nleaf_in  = nleaf_ff;
      nodes_in  = nodes_ff;
      keyid_in  = keyid_ff;
      rid_in    = rid_ff;
      key_in    = key_ff;
      rcnt_in   = rcnt_ff;
      merge_in  = merge_ff;
      long_in   = long_ff;
      sat_in    = sat_ff;
      hv_q_in   = hv_q_ff;
      hvalid_in = hvalid_ff;
      pbits_in  = pbits_ff;
      pcnt_in   = pcnt_ff;
      tot_in    = tot_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;

      hist_wr_en   = 1'b0;
      hist_wr_addr = sym_ff;
      hist_wr_data = hist_cur + 1'b1;
      hist_rd_en   = 1'b0;
      hist_rd_addr = idx_ff[SW-1:0];
      code_wr_en   = 1'b0;
      code_wr_addr = idx_ff[SW-1:0];
      code_wr_data = '0;
      code_rd_en   = 1'b0;
      code_rd_addr = item.symbol;
      list_wr_en   = 1'b0;
      list_wr_addr = j_ff;
      list_wr_data = list_rd_data;
      list_rd_en   = 1'b0;
      list_rd_addr = j_ff - 1'b1;
      node_wr_en   = 1'b0;
      node_wr_addr = nleaf_ff;
      node_wr_data = '0;
      node_rd_en   = 1'b0;
      node_rd_addr = idx_ff;
      dc_wr_en     = 1'b0;
      dc_wr_addr   = node_rd_data.left;
      dc_wr_data   = '0;
      dc_rd_en     = 1'b0;
      dc_rd_addr   = idx_ff;

      unique case (state_ff)
         hbe_pkg::S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               sym_in   = item.symbol;
               unique case (item.op)
                  hbe_pkg::OP_COUNT: begin
                     hist_rd_en   = 1'b1;
                     hist_rd_addr = item.symbol;
                     hv_q_in      = hvalid_ff[item.symbol];
                  end
                  hbe_pkg::OP_BUILD: begin
                     idx_in   = '0;
                     n_in     = '0;
                     nleaf_in = '0;
                     nodes_in = '0;
                     long_in  = 1'b0;
                  end
                  hbe_pkg::OP_ENCODE: code_rd_en = 1'b1;
                  hbe_pkg::OP_FLUSH: begin
                  end
               endcase
            end
         end
         hbe_pkg::S_CNT_WR: begin
            if (hist_cur == CMAX) begin
               sat_in = 1'b1;
            end else begin
               hist_wr_en        = 1'b1;
               hvalid_in[sym_ff] = 1'b1;
            end
         end
         hbe_pkg::S_ENC_CHK: begin
            if (code_long) begin
               res_push      = !res_full;
               res.kind      = hbe_pkg::KIND_DATA;
               res.status    = hbe_pkg::ST_LONG;
               res.last      = 1'b1;
            end else begin
               tot_in = tot_next;
               acc_in = enc_acc;
               rem_in = enc_rem;
               if (enc_rem < hbe_pkg::REM_W'(8)) begin
                  pbits_in = enc_acc[7:0];
                  pcnt_in  = enc_rem[2:0];
               end
            end
         end
         hbe_pkg::S_ENC_EMIT: begin
            if (!res_full) begin
               res_push     = 1'b1;
               res.kind     = hbe_pkg::KIND_DATA;
               res.out_byte = acc_ff[7:0];
               res.status   = hbe_pkg::ST_OK;
               res.last     = (rem_m8 < hbe_pkg::REM_W'(8));
               acc_in       = acc_ff >> 8;
               rem_in       = rem_m8;
               if (rem_m8 < hbe_pkg::REM_W'(8)) begin
                  pbits_in = acc_ff[15:8];
                  pcnt_in  = rem_m8[2:0];
               end
            end
         end
         hbe_pkg::S_FL_BYTE: begin
            if (pcnt_ff != '0 && !res_full) begin
               res_push     = 1'b1;
               res.kind     = hbe_pkg::KIND_DATA;
               res.out_byte = pbits_ff;
               res.status   = hbe_pkg::ST_OK;
            end
         end
         hbe_pkg::S_FL_TOT: begin
            if (!res_full) begin
               res_push      = 1'b1;
               res.kind      = hbe_pkg::KIND_TOTAL;
               res.bit_total = tot_ff;
               res.status    = sat_ff ? hbe_pkg::ST_SAT : hbe_pkg::ST_OK;
               res.last      = 1'b1;
               pbits_in      = '0;
               pcnt_in       = '0;
               tot_in        = '0;
            end
         end
         hbe_pkg::S_SC_RD: begin
            // read the count and drop any old code of this symbol
            hist_rd_en = 1'b1;
            hv_q_in    = hvalid_ff[idx_ff[SW-1:0]];
            code_wr_en = 1'b1;
         end
         hbe_pkg::S_SC_CHK: begin
            if (hist_cur != '0) begin
               node_wr_en        = 1'b1;
               node_wr_data.left = NW'(idx_ff[SW-1:0]);
               key_in            = hbe_pkg::SUM_W'(hist_cur);
               keyid_in          = nleaf_ff;
               j_in              = n_ff;
               merge_in          = 1'b0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         hbe_pkg::S_IN_RD: begin
            if (j_ff != '0) list_rd_en = 1'b1;
         end
         hbe_pkg::S_IN_CMP: begin
            if (list_less) begin
               list_wr_en = 1'b1;
               j_in       = j_ff - 1'b1;
            end
         end
         hbe_pkg::S_IN_PUT: begin
            list_wr_en         = 1'b1;
            list_wr_data.count = key_ff;
            list_wr_data.id    = keyid_ff;
            n_in               = n_ff + 1'b1;
            nodes_in           = nodes_ff + 1'b1;
            if (!merge_ff) begin
               nleaf_in = nleaf_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
            end
         end
         hbe_pkg::S_MG_START: begin
            if (n_ff > NW'(1)) begin
               list_rd_en   = 1'b1;
               list_rd_addr = n_ff - 1'b1;
            end else if (nleaf_ff != '0) begin
               dc_wr_en   = 1'b1;
               dc_wr_addr = nodes_ff - 1'b1;
               idx_in     = nodes_ff - 1'b1;
            end
         end
         hbe_pkg::S_MG_R: begin
            rcnt_in      = list_rd_data.count;
            rid_in       = list_rd_data.id;
            list_rd_en   = 1'b1;
            list_rd_addr = n_ff - NW'(2);
         end
         hbe_pkg::S_MG_L: begin
            node_wr_en         = 1'b1;
            node_wr_addr       = nodes_ff;
            node_wr_data.left  = list_rd_data.id;
            node_wr_data.right = rid_ff;
            key_in             = rcnt_ff + list_rd_data.count;
            keyid_in           = nodes_ff;
            n_in               = n_ff - NW'(2);
            j_in               = n_ff - NW'(2);
            merge_in           = 1'b1;
         end
         hbe_pkg::S_TR_CHK: begin
            if (idx_ff >= nleaf_ff) begin
               node_rd_en = 1'b1;
               dc_rd_en   = 1'b1;
            end else begin
               idx_in = '0;
            end
         end
         hbe_pkg::S_TR_W1: begin
            dc_wr_en         = 1'b1;
            dc_wr_data.depth = dc_rd_data.depth + 1'b1;
            dc_wr_data.code  = dc_rd_data.code;
         end
         hbe_pkg::S_TR_W2: begin
            dc_wr_en         = 1'b1;
            dc_wr_addr       = node_rd_data.right;
            dc_wr_data.depth = dc_rd_data.depth + 1'b1;
            dc_wr_data.code  = dc_rd_data.code;
            if (32'(dc_rd_data.depth) < hbe_pkg::CODE_W) begin
               dc_wr_data.code = dc_rd_data.code
                               | (hbe_pkg::CODE_W'(1) << dc_rd_data.depth);
            end
            idx_in = idx_ff - 1'b1;
         end
         hbe_pkg::S_AS_RD: begin
            node_rd_en = 1'b1;
            dc_rd_en   = 1'b1;
         end
         hbe_pkg::S_AS_WR: begin
            code_wr_en        = 1'b1;
            code_wr_addr      = node_rd_data.left[SW-1:0];
            code_wr_data.bits = dc_rd_data.code;
            code_wr_data.len  = (32'(dc_rd_data.depth) > hbe_pkg::LEN_MAX)
                              ? hbe_pkg::LEN_W'(hbe_pkg::LEN_MAX)
                              : dc_rd_data.depth[hbe_pkg::LEN_W-1:0];
            if (32'(dc_rd_data.depth) > hbe_pkg::MAX_LEN) long_in = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         hbe_pkg::S_BD_RES: begin
            if (!res_full) begin
               res_push   = 1'b1;
               res.kind   = hbe_pkg::KIND_DATA;
               res.status = long_ff ? hbe_pkg::ST_LONG
                          : (sat_ff ? hbe_pkg::ST_SAT : hbe_pkg::ST_OK);
               res.last   = 1'b1;
               pbits_in   = '0;
               pcnt_in    = '0;
               tot_in     = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hbe_pkg::S_IDLE;
         idx_ff    <= '0;
         j_ff      <= '0;
         n_ff      <= '0;
         nleaf_ff  <= '0;
         nodes_ff  <= '0;
         merge_ff  <= 1'b0;
         long_ff   <= 1'b0;
         sat_ff    <= 1'b0;
         hvalid_ff <= '0;
         pbits_ff  <= '0;
         pcnt_ff   <= '0;
         tot_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         j_ff      <= j_in;
         n_ff      <= n_in;
         nleaf_ff  <= nleaf_in;
         nodes_ff  <= nodes_in;
         merge_ff  <= merge_in;
         long_ff   <= long_in;
         sat_ff    <= sat_in;
         hvalid_ff <= hvalid_in;
         pbits_ff  <= pbits_in;
         pcnt_ff   <= pcnt_in;
         tot_ff    <= tot_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff   <= sym_in;
      keyid_ff <= keyid_in;
      rid_ff   <= rid_in;
      key_ff   <= key_in;
      rcnt_ff  <= rcnt_in;
      hv_q_ff  <= hv_q_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
   end

endmodule

`default_nettype wire

>>> rtl/huffman_byte_encoder_unit.sv
// Top level of the two-pass Huffman byte encoder.
// Depends on hbe_pkg, hbe_front, hbe_back and hbe_outq.
//
//   channel   ports                                   accepted when
//   -------   -------------------------------------   -------------------
//   input     push, full, req_func, req_symbol         push && !full
//   result    empty, pop, rsp_kind, rsp_out_byte,      pop && !empty
//             rsp_bit_total, rsp_status, rsp_last
//
// A count item reads the histogram, then writes it; an encode item checks the code,
// then emits each completed byte; a flush emits any partial byte, then the bit total.
// A build item sweeps all 256 histogram entries, then runs the sorted-list insertions
// (moving entries, then placing the entry), a merge before each later insertion, a
// code walk over the internal nodes and a code table write per leaf.
// Reset clears the histogram at once through per-entry valid flags; no clearing pass.
// Items queue in a 2-entry input queue while the back end works, and results wait in
// a 4-entry result queue, so either side may stall without losing an item.
`default_nettype none

module huffman_byte_encoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_symbol,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [39:0]      rsp_bit_total,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);

   hbe_pkg::item_type item;
   hbe_pkg::res_type  res, head;
   logic              item_valid, item_pop, res_push, res_full;

   // accept and classify items
   hbe_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_func(req_func), .req_symbol(req_symbol),
      .item_valid(item_valid), .item(item), .item_pop(item_pop));

   // carry them out: histogram, tree build, packing
   hbe_back u_back (
      .clock(clock), .reset(reset), .item_valid(item_valid), .item(item),
      .item_pop(item_pop), .res_full(res_full), .res_push(res_push), .res(res));

   // hold results until taken
   hbe_outq u_outq (
      .clock(clock), .reset(reset), .res_push(res_push), .res(res),
      .res_full(res_full), .empty(empty), .pop(pop), .head(head));

   assign rsp_kind      = head.kind;
   assign rsp_out_byte  = head.out_byte;
   assign rsp_bit_total = head.bit_total;
   assign rsp_status    = head.status;
   assign rsp_last      = head.last;

endmodule

`default_nettype wire

>>> rtl/hbe_checker.sv
// Port-level checks on the results of the encoder, bound to the top level.
// Depends on hbe_pkg and huffman_byte_encoder_unit.
`default_nettype none

module hbe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        empty,
   input wire logic        rsp_kind,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic [39:0] rsp_bit_total,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_total_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == hbe_pkg::KIND_TOTAL) |-> (rsp_last && rsp_out_byte == 8'd0))
      else $error("bit total item not final or carries data");

   a_data_total: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == hbe_pkg::KIND_DATA) |-> (rsp_bit_total == 40'd0))
      else $error("data item carries a bit total");

   a_long_final: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status == hbe_pkg::ST_LONG)
         |-> (rsp_last && rsp_kind == hbe_pkg::KIND_DATA && rsp_out_byte == 8'd0))
      else $error("over-long report malformed");

endmodule

bind huffman_byte_encoder_unit hbe_checker u_checker (
   .clock(clock), .reset(reset), .empty(empty), .rsp_kind(rsp_kind),
   .rsp_out_byte(rsp_out_byte), .rsp_bit_total(rsp_bit_total),
   .rsp_status(rsp_status), .rsp_last(rsp_last));

`default_nettype wire
